@@ rtl/core/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, ignored while in reset
`define CHK_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication, ignored while in reset
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// next-cycle implication, also checked through reset
`define CHK_NEXT_NORST(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("reset check failed");

`endif

@@ rtl/core/lfu_pkg.sv @@
// shared constants and types of the lfu page replacement block
package lfu_pkg;

  localparam int FRAMES     = 8;
  localparam int PAGE_BITS  = 16;
  localparam int COUNT_BITS = 32;

  // fixed field widths of the ports
  localparam int PAGE_W     = 16;
  localparam int FIDX_W     = 3;
  localparam int TOTAL_BITS = 32;
  localparam int CFG_W      = 4;

  // internal frame index width
  localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  // candidates left after the first comparison level
  localparam int L1_N  = (FRAMES + 1) / 2;

  // request queue depth between front and back
  localparam int QDEPTH = 2;
  localparam int Q_AW   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int Q_CW   = $clog2(QDEPTH + 1);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};

  // head of the request queue as seen by the back end
  typedef struct packed {
    logic                 valid;
    logic [PAGE_BITS-1:0] page;
  } q_head_t;

endpackage

@@ rtl/core/lfu_if.sv @@
// request and result channel interfaces
interface lfu_req_if import lfu_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PAGE_W-1:0] page;

  modport source (output valid, output page, input ready);
  modport sink (input valid, input page, output ready);
endinterface

interface lfu_res_if import lfu_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  hit;
  logic [FIDX_W-1:0]     frame_index;
  logic                  evicted_valid;
  logic [PAGE_W-1:0]     evicted_page;
  logic [TOTAL_BITS-1:0] fault_count;

  modport source (output valid, output hit, output frame_index, output evicted_valid,
                  output evicted_page, output fault_count, input ready);
  modport sink (input valid, input hit, input frame_index, input evicted_valid,
                input evicted_page, input fault_count, output ready);
endinterface

@@ rtl/core/lfu_front.sv @@
// front end: takes requests and holds them in a short queue
module lfu_front import lfu_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  lfu_req_if.sink req,
  input  logic    pop,
  output q_head_t head
);

  logic [PAGE_BITS-1:0] q_mem_r [QDEPTH];
  logic [Q_AW-1:0]      wr_ptr_r;
  logic [Q_AW-1:0]      rd_ptr_r;
  logic [Q_CW-1:0]      count_r;
  logic                 push;
  logic                 do_pop;

  assign req.ready  = (count_r != Q_CW'(QDEPTH));
  assign push       = req.valid && req.ready;
  assign head.valid = (count_r != '0);
  assign head.page  = q_mem_r[rd_ptr_r];
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == Q_AW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == Q_AW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (!push && do_pop) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= PAGE_BITS'(req.page);
    end
  end

endmodule

@@ rtl/core/lfu_back.sv @@
// back end: tag match, least-count search and frame table update
module lfu_back import lfu_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CFG_W-1:0] frames_cfg,
  input  q_head_t          head,
  output logic             pop,
  lfu_res_if.source        res
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_COMMIT = 3'b100
  } back_st_t;

  back_st_t st_r, st_nxt;

  // frame table
  logic [PAGE_BITS-1:0]  frame_page_r [FRAMES];
  logic [FRAMES-1:0]     frame_valid_r;
  logic [COUNT_BITS-1:0] use_count_r [FRAMES];
  logic [TOTAL_BITS-1:0] fault_total_r;

  logic [PAGE_BITS-1:0]  req_page_r;

  // scan results
  logic                  hit_r, hit_c;
  logic [IDX_W-1:0]      hit_idx_r, hit_idx_c;
  logic [COUNT_BITS-1:0] l1_cnt_r [L1_N];
  logic [IDX_W-1:0]      l1_idx_r [L1_N];
  logic [COUNT_BITS-1:0] l1_cnt_c [L1_N];
  logic [IDX_W-1:0]      l1_idx_c [L1_N];
  logic [COUNT_BITS-1:0] eff_cnt [FRAMES];
  logic [FRAMES-1:0]     active;

  // commit side
  logic [COUNT_BITS-1:0] best_cnt;
  logic [IDX_W-1:0]      best_idx;
  logic [IDX_W-1:0]      slot;
  logic                  do_commit;
  logic [TOTAL_BITS-1:0] total_upd;
  logic [COUNT_BITS-1:0] cnt_upd;

  // result register
  logic                  out_valid_r;
  logic                  res_hit_r;
  logic [FIDX_W-1:0]     res_idx_r;
  logic                  res_ev_valid_r;
  logic [PAGE_W-1:0]     res_ev_page_r;
  logic [TOTAL_BITS-1:0] res_total_r;

  // frame 0 always takes part, otherwise only frames below the configured count do
  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      active[i] = (i == 0) || (32'(frames_cfg) > 32'(i));
    end
  end

  always_comb begin
    hit_c     = 1'b0;
    hit_idx_c = '0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (active[i] && frame_valid_r[i] && (frame_page_r[i] == req_page_r)) begin
        hit_c     = 1'b1;
        hit_idx_c = IDX_W'(i);
      end
    end
    // empty frames count as zero, inactive ones can never win
    for (int i = 0; i < FRAMES; i++) begin
      if (!active[i]) begin
        eff_cnt[i] = COUNT_MAX;
      end else if (frame_valid_r[i]) begin
        eff_cnt[i] = use_count_r[i];
      end else begin
        eff_cnt[i] = '0;
      end
    end
    // first level, lower index kept on ties
    for (int j = 0; j < L1_N; j++) begin
      l1_cnt_c[j] = eff_cnt[2*j];
      l1_idx_c[j] = IDX_W'(2*j);
      if ((2*j + 1) < FRAMES) begin
        if (eff_cnt[2*j+1] < eff_cnt[2*j]) begin
          l1_cnt_c[j] = eff_cnt[2*j+1];
          l1_idx_c[j] = IDX_W'(2*j + 1);
        end
      end
    end
  end

  always_comb begin
    best_cnt = l1_cnt_r[0];
    best_idx = l1_idx_r[0];
    for (int j = 1; j < L1_N; j++) begin
      if (l1_cnt_r[j] < best_cnt) begin
        best_cnt = l1_cnt_r[j];
        best_idx = l1_idx_r[j];
      end
    end
  end

  assign slot      = hit_r ? hit_idx_r : best_idx;
  assign do_commit = (st_r == ST_COMMIT) && (!out_valid_r || res.ready);
  assign total_upd = (fault_total_r != TOTAL_MAX) ? fault_total_r + 1'b1 : fault_total_r;
  assign cnt_upd   = (use_count_r[slot] != COUNT_MAX) ? use_count_r[slot] + 1'b1
                                                      : use_count_r[slot];

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: begin
        if (head.valid) begin
          st_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        st_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (do_commit) begin
          st_nxt = head.valid ? ST_SCAN : ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  assign pop = head.valid && ((st_r == ST_IDLE) || do_commit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r          <= ST_IDLE;
      frame_valid_r <= '0;
      fault_total_r <= '0;
      out_valid_r   <= 1'b0;
      for (int i = 0; i < FRAMES; i++) begin
        use_count_r[i] <= '0;
      end
    end else begin
      st_r <= st_nxt;
      if (do_commit) begin
        out_valid_r <= 1'b1;
      end else if (res.ready) begin
        out_valid_r <= 1'b0;
      end
      if (do_commit) begin
        if (hit_r) begin
          use_count_r[slot] <= cnt_upd;
        end else begin
          use_count_r[slot]   <= COUNT_BITS'(1);
          frame_valid_r[slot] <= 1'b1;
          fault_total_r       <= total_upd;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      req_page_r <= head.page;
    end
    if (st_r == ST_SCAN) begin
      hit_r     <= hit_c;
      hit_idx_r <= hit_idx_c;
      for (int j = 0; j < L1_N; j++) begin
        l1_cnt_r[j] <= l1_cnt_c[j];
        l1_idx_r[j] <= l1_idx_c[j];
      end
    end
    if (do_commit) begin
      if (!hit_r) begin
        frame_page_r[slot] <= req_page_r;
      end
      res_hit_r      <= hit_r;
      res_idx_r      <= FIDX_W'(slot);
      res_ev_valid_r <= !hit_r && frame_valid_r[slot];
      res_ev_page_r  <= (!hit_r && frame_valid_r[slot]) ? PAGE_W'(frame_page_r[slot]) : '0;
      res_total_r    <= hit_r ? fault_total_r : total_upd;
    end
  end

  assign res.valid         = out_valid_r;
  assign res.hit           = res_hit_r;
  assign res.frame_index   = res_idx_r;
  assign res.evicted_valid = res_ev_valid_r;
  assign res.evicted_page  = res_ev_page_r;
  assign res.fault_count   = res_total_r;

endmodule

@@ rtl/core/lfu_page_replacement.sv @@
// top level of the lfu page replacement block
//
// in_req carries one page request per handshake (valid/ready, 16-bit page)
// out_res returns one result per request, in order: hit flag, frame index,
// evicted page with its valid flag, and the saturating fault total
// cfg_we/cfg_wdata write frames_in_use (0 acts as 1, above 8 acts as 8);
// write it only while no request is in flight
//
// latency: a request accepted at one edge shows its result three edges later
// at the earliest (queue, scan, commit)
// throughput: one request every 2 cycles, set by the back end's scan/commit
// loop, since each lookup needs the counts left by the previous one
//
// reset (synchronous, active low) empties the queue, marks all frames empty,
// clears use counts and the fault total, and sets frames_in_use to 8;
// no clearing pass is needed
// when the receiver stalls, the result stays in the output register, the
// back end holds its commit and the 2-entry queue keeps taking requests
// until full, then in_req.ready drops
module lfu_page_replacement import lfu_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  lfu_req_if.sink          in_req,
  lfu_res_if.source        out_res,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  // frames_in_use register
  logic [CFG_W-1:0] cfg_frames_r;
  // queue head toward the back end
  q_head_t          head;
  logic             pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_frames_r <= CFG_W'(FRAMES);
    end else if (cfg_we) begin
      cfg_frames_r <= cfg_wdata;
    end
  end

  // front end: request queue
  lfu_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (in_req),
    .pop   (pop),
    .head  (head)
  );

  // back end: match, victim search, table update and result register
  lfu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .frames_cfg (cfg_frames_r),
    .head       (head),
    .pop        (pop),
    .res        (out_res)
  );

endmodule

@@ rtl/core/lfu_checker.sv @@
// port-level checks of the lfu page replacement block and their binding
`include "assert_macros.svh"

module lfu_checker import lfu_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic                  out_hit,
  input logic                  out_evicted_valid,
  input logic [PAGE_W-1:0]     out_evicted_page,
  input logic [TOTAL_BITS-1:0] out_fault_count
);

  `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `CHK_IMPLY(a_hit_no_evict, clk, rst_n, out_valid && out_hit, !out_evicted_valid && (out_evicted_page == '0))
  `CHK_IMPLY(a_miss_counted, clk, rst_n, out_valid && !out_hit, out_fault_count != '0)
  `CHK_NEXT_NORST(a_reset_idle, clk, !rst_n, !out_valid)

endmodule

bind lfu_page_replacement lfu_checker u_lfu_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_res.valid),
  .out_ready         (out_res.ready),
  .out_hit           (out_res.hit),
  .out_evicted_valid (out_res.evicted_valid),
  .out_evicted_page  (out_res.evicted_page),
  .out_fault_count   (out_res.fault_count)
);
